### src/bps_pkg.sv
// Shared constants and the arctangent table of the ballistic pitch solver.
package bps_pkg;

	// Field widths of the request, the response and the gravity setting.
	localparam int SPEED_W = 16;
	localparam int DIST_W = 15;
	localparam int HEIGHT_W = 15;
	localparam int PITCH_W = 18;
	localparam int TIME_W = 24;
	localparam int GRAV_W = 20;

	// Gravity after reset, in 2^-16 m/s^2.
	localparam logic [GRAV_W-1:0] GRAV_RESET = 20'd641154;

	// Largest pitch magnitude, in 2^-16 rad.
	localparam logic [PITCH_W-1:0] PITCH_LIMIT = 18'd102944;

	// Number of rotation steps of the angle unit.
	localparam int CORDIC_STEPS = 30;

	// Arctangent of 2^-i in Q30 radians.
	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] val;
		case (i)
			0: val = 30'd843314857;
			1: val = 30'd497837829;
			2: val = 30'd263043837;
			3: val = 30'd133525159;
			4: val = 30'd67021687;
			5: val = 30'd33543516;
			6: val = 30'd16775851;
			7: val = 30'd8388437;
			8: val = 30'd4194283;
			9: val = 30'd2097149;
			10: val = 30'd1048576;
			11: val = 30'd524288;
			12: val = 30'd262144;
			13: val = 30'd131072;
			14: val = 30'd65536;
			15: val = 30'd32768;
			16: val = 30'd16384;
			17: val = 30'd8192;
			18: val = 30'd4096;
			19: val = 30'd2048;
			20: val = 30'd1024;
			21: val = 30'd512;
			22: val = 30'd256;
			23: val = 30'd128;
			24: val = 30'd64;
			25: val = 30'd32;
			26: val = 30'd16;
			27: val = 30'd8;
			28: val = 30'd4;
			29: val = 30'd2;
			default: val = 30'd0;
		endcase
		return val;
	endfunction

endpackage

### src/bps_if.sv
// Request and response channel interfaces of the ballistic pitch solver.
interface bps_req_if;
	logic valid;
	logic ready;
	logic [bps_pkg::SPEED_W-1:0] muzzle_speed;
	logic [bps_pkg::DIST_W-1:0] distance;
	logic signed [bps_pkg::HEIGHT_W-1:0] height;

	modport source (output valid, output muzzle_speed, output distance, output height,
		input ready);
	modport sink (input valid, input muzzle_speed, input distance, input height,
		output ready);
endinterface

interface bps_rsp_if;
	logic valid;
	logic ready;
	logic no_solution;
	logic signed [bps_pkg::PITCH_W-1:0] pitch_angle;
	logic [bps_pkg::TIME_W-1:0] flight_time;

	modport source (output valid, output no_solution, output pitch_angle, output flight_time,
		input ready);
	modport sink (input valid, input no_solution, input pitch_angle, input flight_time,
		output ready);
endinterface

### src/bps_wmul.sv
// Two-stage wide multiplier built from four 32 by 32 partial products.
module bps_wmul #(
	parameter int WA = 32,
	parameter int WB = 32,
	parameter int WS = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic [WA-1:0] a,
	input logic [WB-1:0] b,
	input logic [WS-1:0] side_in,
	output logic out_vld,
	output logic [WA+WB-1:0] p,
	output logic [WS-1:0] side_out
);

	logic [63:0] a64;
	logic [63:0] b64;
	logic [63:0] pp00_s1;
	logic [63:0] pp01_s1;
	logic [63:0] pp10_s1;
	logic [63:0] pp11_s1;
	logic [127:0] sum;
	logic vld_s1;
	logic vld_s2;
	logic [WS-1:0] side_s1;
	logic [WS-1:0] side_s2;
	logic [WA+WB-1:0] p_s2;

	assign a64 = 64'(a);
	assign b64 = 64'(b);

	// Valid bits follow the data through both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// Partial products of the two halves of each operand.
	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1 <= 64'(a64[31:0]) * 64'(b64[31:0]);
			pp01_s1 <= 64'(a64[31:0]) * 64'(b64[63:32]);
			pp10_s1 <= 64'(a64[63:32]) * 64'(b64[31:0]);
			pp11_s1 <= 64'(a64[63:32]) * 64'(b64[63:32]);
			side_s1 <= side_in;
			p_s2 <= sum[WA+WB-1:0];
			side_s2 <= side_s1;
		end
	end

	// Weighted sum of the partial products.
	assign sum = 128'(pp00_s1) + (128'(pp01_s1) << 32) + (128'(pp10_s1) << 32)
		+ (128'(pp11_s1) << 64);

	assign out_vld = vld_s2;
	assign p = p_s2;
	assign side_out = side_s2;

endmodule

### src/bps_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module bps_sqrt #(
	parameter int WN = 8,
	parameter int WR = 4,
	parameter int WS = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic [WN-1:0] n,
	input logic [WS-1:0] side_in,
	output logic out_vld,
	output logic [WR-1:0] root,
	output logic [WS-1:0] side_out
);

	localparam int WT = 2 * WR + 1;

	logic [WT-1:0] rem_s [0:WR];
	logic [WR-1:0] root_s [0:WR];
	logic [WS-1:0] side_s [0:WR];
	logic vld_s [0:WR];

	// Stage zero is the incoming operand.
	assign rem_s[0] = WT'(n);
	assign root_s[0] = '0;
	assign side_s[0] = side_in;
	assign vld_s[0] = in_vld;

	for (genvar j = 0; j < WR; j++) begin : g_stage
		localparam int B = WR - 1 - j;
		logic [WT-1:0] trial;

		// Growth of the square when bit B of the root is set.
		assign trial = (WT'(root_s[j]) << (B + 1)) + (WT'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j+1] <= side_s[j];
				if (trial <= rem_s[j]) begin
					rem_s[j+1] <= rem_s[j] - trial;
					root_s[j+1] <= root_s[j] | (WR'(1) << B);
				end else begin
					rem_s[j+1] <= rem_s[j];
					root_s[j+1] <= root_s[j];
				end
			end
		end
	end

	assign out_vld = vld_s[WR];
	assign root = root_s[WR];
	assign side_out = side_s[WR];

endmodule

### src/ballistic_pitch_solver.sv
// Throughput: one request per cycle while the response is not stalled;
// every unit is a pipeline stage and the longest path is the 57-stage
// square root of the flight distance.
// A stalled response holds every stage in place; nothing is lost or repeated.
// Reset clears all valid bits and sets gravity to its default value.
module ballistic_pitch_solver (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [bps_pkg::GRAV_W-1:0] cfg_data,
	bps_req_if.sink req,
	bps_rsp_if.source rsp
);

	localparam int R1_W = 40;
	localparam int R2_W = 57;
	localparam int DIV_B = 24;
	localparam int STEPS = bps_pkg::CORDIC_STEPS;
	localparam int DLY = (2 + 1 + R2_W + 1 + DIV_B) - (2 + STEPS + 1);

	typedef struct packed {
		logic [38:0] k;
		logic [53:0] magc;
		logic cneg;
		logic [15:0] v;
		logic [14:0] d;
		logic nosol;
	} side1_t;

	logic [bps_pkg::GRAV_W-1:0] gravity_q;
	logic en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s7, vld_s48, vld_s49, vld_s52, vld_s110;
	logic [15:0] v_s1, v_s2, v_s3, v_s4;
	logic [14:0] d_s1, d_s2, d_s3, d_s4;
	logic signed [14:0] h_s1, h_s2;
	logic degen_s1, degen_s2, degen_s3, degen_s4;
	logic [31:0] v2_s1;
	logic [29:0] d2_s1;
	logic [38:0] k_s2, k_s3, k_s4;
	logic [49:0] a_s2, a_s3;
	logic signed [54:0] hk_s3;
	logic signed [54:0] c_sum;
	logic [53:0] magc_s4;
	logic cneg_s4, cpos_s4;

	logic kk_vld, q_vld;
	logic [77:0] kk_p;
	logic [75:0] q_p;
	logic [70:0] kk_side;
	logic [55:0] q_side;
	logic [38:0] k_s6;
	logic [15:0] v_s6;
	logic [14:0] d_s6;
	logic degen_s6;
	logic [53:0] magc_s6;
	logic cneg_s6, cpos_s6;

	logic [78:0] e_s7;
	side1_t side1_s7;
	logic r1_vld;
	logic [R1_W-1:0] r1;
	side1_t side1_out;

	logic [40:0] kr_s48;
	logic [53:0] magc_s48;
	logic cneg_s48, nosol_s48;
	logic [15:0] v_s48;
	logic [14:0] d_s48;

	logic [55:0] x_s49;
	logic [54:0] ay_s49;
	logic [56:0] dn_s49;
	logic cneg_s49, nosol_s49;

	logic [55:0] xn1_s50, yn1_s50;
	logic [29:0] xn_s51, yn_s51;
	logic cneg_s50, cneg_s51;
	logic [55:0] xa1, ya1, xa2, ya2;

	logic signed [33:0] cx_s [0:STEPS];
	logic signed [33:0] cy_s [0:STEPS];
	logic signed [32:0] cz_s [0:STEPS];
	logic cneg_c_s [0:STEPS];
	logic yz_c_s [0:STEPS];

	logic [18:0] zround;
	logic [17:0] pmag;
	logic signed [17:0] pitch_s82;
	logic signed [17:0] pd_s [0:DLY];

	logic xx_vld, yy_vld;
	logic [111:0] xx_p;
	logic [109:0] yy_p;
	logic [56:0] dn_s51;
	logic nosol_s51;
	logic [112:0] ss_s52;
	logic [56:0] dn_s52;
	logic nosol_s52;
	logic r2_vld;
	logic [R2_W-1:0] r2;
	logic [57:0] side2_out;
	logic [76:0] num_s110;
	logic [56:0] dn_s110;
	logic nosol_s110;

	logic [76:0] dv_rem_s [0:DIV_B];
	logic [DIV_B-1:0] dv_q_s [0:DIV_B];
	logic [56:0] dv_dn_s [0:DIV_B];
	logic dv_ns_s [0:DIV_B];
	logic dv_vld_s [0:DIV_B];

	logic out_vld_q;
	logic nosol_q;
	logic signed [17:0] pitch_q;
	logic [DIV_B-1:0] time_q;

	// The whole pipeline moves whenever the output register can take a result.
	assign en = !out_vld_q || rsp.ready;
	assign req.ready = en;

	// Gravity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= bps_pkg::GRAV_RESET;
		end else if (cfg_we) begin
			gravity_q <= cfg_data;
		end
	end

	// Valid bits of the stages around the multiplier and square root units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s48 <= 1'b0;
			vld_s49 <= 1'b0;
			vld_s52 <= 1'b0;
			vld_s110 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s7 <= kk_vld & q_vld;
			vld_s48 <= r1_vld;
			vld_s49 <= vld_s48;
			vld_s52 <= xx_vld & yy_vld;
			vld_s110 <= r2_vld;
		end
	end

	// Squares, then K = 125*v^2 and g*d^2, then h*K, then the signed C.
	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= req.muzzle_speed;
			d_s1 <= req.distance;
			h_s1 <= req.height;
			degen_s1 <= (req.muzzle_speed == '0) || (req.distance == '0);
			v2_s1 <= 32'(req.muzzle_speed) * 32'(req.muzzle_speed);
			d2_s1 <= 30'(req.distance) * 30'(req.distance);

			v_s2 <= v_s1;
			d_s2 <= d_s1;
			h_s2 <= h_s1;
			degen_s2 <= degen_s1;
			k_s2 <= 39'(v2_s1) * 39'd125;
			a_s2 <= 50'(gravity_q) * 50'(d2_s1);

			v_s3 <= v_s2;
			d_s3 <= d_s2;
			degen_s3 <= degen_s2;
			k_s3 <= k_s2;
			a_s3 <= a_s2;
			hk_s3 <= 55'(h_s2) * $signed({16'b0, k_s2});

			v_s4 <= v_s3;
			d_s4 <= d_s3;
			degen_s4 <= degen_s3;
			k_s4 <= k_s3;
			magc_s4 <= c_sum[54] ? 54'(-c_sum) : c_sum[53:0];
			cneg_s4 <= c_sum[54];
			cpos_s4 <= !c_sum[54] && (c_sum != '0);
		end
	end

	assign c_sum = $signed({5'b0, a_s3}) + hk_s3;

	// K^2 and 4*g*|C|.
	bps_wmul #(.WA(39), .WB(39), .WS(71)) u_kk (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s4),
		.a(k_s4), .b(k_s4), .side_in({k_s4, v_s4, d_s4, degen_s4}),
		.out_vld(kk_vld), .p(kk_p), .side_out(kk_side)
	);

	bps_wmul #(.WA(22), .WB(54), .WS(56)) u_q (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s4),
		.a({gravity_q, 2'b00}), .b(magc_s4), .side_in({magc_s4, cneg_s4, cpos_s4}),
		.out_vld(q_vld), .p(q_p), .side_out(q_side)
	);

	assign {k_s6, v_s6, d_s6, degen_s6} = kk_side;
	assign {magc_s6, cneg_s6, cpos_s6} = q_side;

	// Discriminant; a positive C larger than the square bound has no root.
	always_ff @(posedge clk) begin
		if (en) begin
			e_s7 <= cpos_s6 ? 79'(kk_p) - 79'(q_p) : 79'(kk_p) + 79'(q_p);
			side1_s7.k <= k_s6;
			side1_s7.magc <= magc_s6;
			side1_s7.cneg <= cneg_s6;
			side1_s7.v <= v_s6;
			side1_s7.d <= d_s6;
			side1_s7.nosol <= degen_s6 || (cpos_s6 && (78'(q_p) > kk_p));
		end
	end

	bps_sqrt #(.WN(79), .WR(R1_W), .WS($bits(side1_t))) u_sqrt_disc (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s7),
		.n(e_s7), .side_in(side1_s7),
		.out_vld(r1_vld), .root(r1), .side_out(side1_out)
	);

	// K + sqrt(E), then the angle operands and the time divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			kr_s48 <= 41'(side1_out.k) + 41'(r1);
			magc_s48 <= side1_out.magc;
			cneg_s48 <= side1_out.cneg;
			v_s48 <= side1_out.v;
			d_s48 <= side1_out.d;
			nosol_s48 <= side1_out.nosol;

			x_s49 <= 56'(d_s48) * 56'(kr_s48);
			ay_s49 <= {magc_s48, 1'b0};
			dn_s49 <= 57'(v_s48) * 57'(kr_s48);
			cneg_s49 <= cneg_s48;
			nosol_s49 <= nosol_s48;
		end
	end

	// Scale both angle operands below 2^30, coarse shifts first.
	always_comb begin
		logic [55:0] o;
		xa1 = x_s49;
		ya1 = 56'(ay_s49);
		o = xa1 | ya1;
		if (|o[55:45]) begin
			xa1 = xa1 >> 16;
			ya1 = ya1 >> 16;
		end
		o = xa1 | ya1;
		if (|o[55:37]) begin
			xa1 = xa1 >> 8;
			ya1 = ya1 >> 8;
		end
	end

	always_comb begin
		logic [55:0] o;
		xa2 = xn1_s50;
		ya2 = yn1_s50;
		o = xa2 | ya2;
		if (|o[55:33]) begin
			xa2 = xa2 >> 4;
			ya2 = ya2 >> 4;
		end
		o = xa2 | ya2;
		if (|o[55:31]) begin
			xa2 = xa2 >> 2;
			ya2 = ya2 >> 2;
		end
		o = xa2 | ya2;
		if (|o[55:30]) begin
			xa2 = xa2 >> 1;
			ya2 = ya2 >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xn1_s50 <= xa1;
			yn1_s50 <= ya1;
			cneg_s50 <= cneg_s49;
			xn_s51 <= xa2[29:0];
			yn_s51 <= ya2[29:0];
			cneg_s51 <= cneg_s50;
		end
	end

	// Vectoring rotations drive y to zero and collect the angle in z.
	assign cx_s[0] = $signed(34'(xn_s51));
	assign cy_s[0] = $signed(34'(yn_s51));
	assign cz_s[0] = '0;
	assign cneg_c_s[0] = cneg_s51;
	assign yz_c_s[0] = (yn_s51 == '0);

	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		localparam logic signed [32:0] ANG = 33'(bps_pkg::atan_q30(i));
		logic signed [33:0] xs;
		logic signed [33:0] ys;
		logic ypos;

		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;
		assign ypos = !cy_s[i][33] && (cy_s[i] != '0);

		always_ff @(posedge clk) begin
			if (en) begin
				cneg_c_s[i+1] <= cneg_c_s[i];
				yz_c_s[i+1] <= yz_c_s[i];
				if (ypos) begin
					cx_s[i+1] <= cx_s[i] + ys;
					cy_s[i+1] <= cy_s[i] - xs;
					cz_s[i+1] <= cz_s[i] + ANG;
				end else begin
					cx_s[i+1] <= cx_s[i] - ys;
					cy_s[i+1] <= cy_s[i] + xs;
					cz_s[i+1] <= cz_s[i] - ANG;
				end
			end
		end
	end

	// Round the angle to Q16, clamp it, and apply the sign of C.
	assign zround = 19'((cz_s[STEPS] + 33'sd8192) >>> 14);
	always_comb begin
		if (cz_s[STEPS][32] || yz_c_s[STEPS]) begin
			pmag = '0;
		end else if (zround > 19'(bps_pkg::PITCH_LIMIT)) begin
			pmag = bps_pkg::PITCH_LIMIT;
		end else begin
			pmag = zround[17:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_s82 <= cneg_c_s[STEPS] ? -$signed(pmag) : $signed(pmag);
		end
	end

	// Hold the pitch until the flight time of the same request is done.
	assign pd_s[0] = pitch_s82;
	for (genvar k = 0; k < DLY; k++) begin : g_pdly
		always_ff @(posedge clk) begin
			if (en) begin
				pd_s[k+1] <= pd_s[k];
			end
		end
	end

	// Path length sqrt(x^2 + y^2).
	bps_wmul #(.WA(56), .WB(56), .WS(57)) u_xx (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s49),
		.a(x_s49), .b(x_s49), .side_in(dn_s49),
		.out_vld(xx_vld), .p(xx_p), .side_out(dn_s51)
	);

	bps_wmul #(.WA(55), .WB(55), .WS(1)) u_yy (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s49),
		.a(ay_s49), .b(ay_s49), .side_in(nosol_s49),
		.out_vld(yy_vld), .p(yy_p), .side_out(nosol_s51)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s52 <= 113'(xx_p) + 113'(yy_p);
			dn_s52 <= dn_s51;
			nosol_s52 <= nosol_s51;
		end
	end

	bps_sqrt #(.WN(113), .WR(R2_W), .WS(58)) u_sqrt_path (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s52),
		.n(ss_s52), .side_in({dn_s52, nosol_s52}),
		.out_vld(r2_vld), .root(r2), .side_out(side2_out)
	);

	// Dividend in microsecond scale.
	always_ff @(posedge clk) begin
		if (en) begin
			num_s110 <= 77'(r2) * 77'd1024000;
			{dn_s110, nosol_s110} <= side2_out;
		end
	end

	// Restoring division, one quotient bit per stage, saturating at 24 bits.
	assign dv_rem_s[0] = num_s110;
	assign dv_q_s[0] = '0;
	assign dv_dn_s[0] = dn_s110;
	assign dv_ns_s[0] = nosol_s110;
	assign dv_vld_s[0] = vld_s110;

	for (genvar j = 0; j < DIV_B; j++) begin : g_div
		localparam int B = DIV_B - 1 - j;
		logic [80:0] dsh;

		assign dsh = 81'(dv_dn_s[j]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[j+1] <= dv_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_dn_s[j+1] <= dv_dn_s[j];
				dv_ns_s[j+1] <= dv_ns_s[j];
				if (dsh <= 81'(dv_rem_s[j])) begin
					dv_rem_s[j+1] <= dv_rem_s[j] - dsh[76:0];
					dv_q_s[j+1] <= dv_q_s[j] | (DIV_B'(1) << B);
				end else begin
					dv_rem_s[j+1] <= dv_rem_s[j];
					dv_q_s[j+1] <= dv_q_s[j];
				end
			end
		end
	end

	// Output register; an unsolvable request reports zero pitch and time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld_s[DIV_B];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nosol_q <= dv_ns_s[DIV_B];
			pitch_q <= dv_ns_s[DIV_B] ? '0 : pd_s[DLY];
			time_q <= dv_ns_s[DIV_B] ? '0 : dv_q_s[DIV_B];
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.no_solution = nosol_q;
	assign rsp.pitch_angle = pitch_q;
	assign rsp.flight_time = time_q;

endmodule
